[rtl/sprb_pkg.sv]
// Shared types and constants of the serial port ring buffers.
package sprb_pkg;

   localparam int CMD_W      = 3;
   localparam int BYTE_W     = 8;
   localparam int RX_SIZE_W  = 11;
   localparam int RX_COUNT_W = 10;
   localparam int TX_COUNT_W = 8;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [CMD_W-1:0] CMD_RX_BYTE  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TX_READY = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TX_CLEAR = 3'd4;

   localparam logic [REG_IDX_W-1:0] REG_RX_SIZE   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_CONSOLE   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_BREAK_KEY = 2'd2;

   localparam logic [RX_SIZE_W-1:0] RX_SIZE_RESET   = 11'd256;
   localparam logic [BYTE_W-1:0]    BREAK_KEY_RESET = 8'd3;

   typedef struct packed {
      logic [RX_SIZE_W-1:0] rx_size;
      logic                 console_mode;
      logic [BYTE_W-1:0]    break_key;
      logic                 rx_size_wr;
   } cfg_type;

endpackage

[rtl/serial_port_ring_buffers_core.sv]
// Receive and transmit byte rings of one serial port, with config port.
// A request is held in the input register, then its result in the result register.
// Throughput: one request per cycle; a stalled result holds the input register.
// Ring memories: one write and one registered read per ring per cycle.
// Reset is synchronous: pointers and valids clear; ring contents
// are not cleared and there is no clearing pass.
module serial_port_ring_buffers_core #(
   parameter int RX_DEPTH = 1024,
   parameter int TX_DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sprb_pkg::CMD_W-1:0]           req_cmd,
   input  logic [sprb_pkg::BYTE_W-1:0]          req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_read_valid,
   output logic [sprb_pkg::BYTE_W-1:0]          rsp_read_data,
   output logic                                 rsp_write_accepted,
   output logic                                 rsp_send_valid,
   output logic [sprb_pkg::BYTE_W-1:0]          rsp_send_byte,
   output logic                                 rsp_send_done,
   output logic                                 rsp_break_seen,
   output logic [sprb_pkg::RX_COUNT_W-1:0]      rsp_rx_count,
   output logic [sprb_pkg::TX_COUNT_W-1:0]      rsp_tx_count,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sprb_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [sprb_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [sprb_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready
);

   localparam int RA  = $clog2(RX_DEPTH);
   localparam int SW  = $clog2(RX_DEPTH + 1);
   localparam int CW  = (SW > sprb_pkg::RX_SIZE_W) ? SW : sprb_pkg::RX_SIZE_W;
   localparam int RCW = (SW > sprb_pkg::RX_COUNT_W) ? SW : sprb_pkg::RX_COUNT_W;
   localparam int TA  = $clog2(TX_DEPTH);
   localparam int TW  = $clog2(TX_DEPTH + 1);
   localparam int TCW = (TW > sprb_pkg::TX_COUNT_W) ? TW : sprb_pkg::TX_COUNT_W;

   localparam logic [CW-1:0] RX_DEPTH_C = CW'(RX_DEPTH);
   localparam logic [CW-1:0] RX_MIN_C   = CW'(2);
   localparam logic [TW-1:0] TX_DEPTH_C = TW'(TX_DEPTH);

   sprb_pkg::cfg_type cfg;

   sprb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input register
   logic                           in_valid_ff;
   logic [sprb_pkg::CMD_W-1:0]     cmd_ff;
   logic [sprb_pkg::BYTE_W-1:0]    data_ff;
   logic                           out_load;

   assign out_load  = in_valid_ff && (!rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         cmd_ff  <= req_cmd;
         data_ff <= req_data;
      end
   end

   // ring state
   logic [RA-1:0] rx_head_ff, rx_tail_ff, rx_head_in, rx_tail_in;
   logic [TA-1:0] tx_head_ff, tx_tail_ff, tx_head_in, tx_tail_in;
   logic [CW-1:0] size_raw;
   logic [SW-1:0] eff_size, rh, rt, rh_inc, rt_inc, rh_new, rt_new;
   logic [TW-1:0] th, tt, th_inc, tt_inc, th_new, tt_new;
   logic          rv, wa, sv, sd, bk, rx_we, tx_we, brk_hit;
   logic [RCW-1:0] rc;
   logic [TCW-1:0] tc;

   assign size_raw = CW'(cfg.rx_size);
   assign eff_size = (size_raw < RX_MIN_C)   ? SW'(2) :
                     (size_raw > RX_DEPTH_C) ? SW'(RX_DEPTH) : SW'(size_raw);

   assign rh = (SW'(rx_head_ff) >= eff_size) ? '0 : SW'(rx_head_ff);
   assign rt = (SW'(rx_tail_ff) >= eff_size) ? '0 : SW'(rx_tail_ff);
   assign rh_inc = ((rh + SW'(1)) >= eff_size) ? '0 : rh + SW'(1);
   assign rt_inc = ((rt + SW'(1)) >= eff_size) ? '0 : rt + SW'(1);

   assign th = TW'(tx_head_ff);
   assign tt = TW'(tx_tail_ff);
   assign th_inc = ((th + TW'(1)) >= TX_DEPTH_C) ? '0 : th + TW'(1);
   assign tt_inc = ((tt + TW'(1)) >= TX_DEPTH_C) ? '0 : tt + TW'(1);

   assign brk_hit = cfg.console_mode && (cfg.break_key != '0) && (data_ff == cfg.break_key);

   always_comb begin
      rh_new = rh;
      rt_new = rt;
      th_new = th;
      tt_new = tt;
      rv     = 1'b0;
      wa     = 1'b0;
      sv     = 1'b0;
      sd     = 1'b0;
      bk     = 1'b0;
      rx_we  = 1'b0;
      tx_we  = 1'b0;
      case (cmd_ff)
         sprb_pkg::CMD_RX_BYTE: begin
            rx_we = 1'b1;
            if (brk_hit) begin
               rh_new = rt;
               bk     = 1'b1;
            end else begin
               rh_new = rh_inc;
               if (rh_inc == rt) begin
                  rt_new = rt_inc;
               end
            end
         end
         sprb_pkg::CMD_READ: begin
            if (rh != rt) begin
               rv     = 1'b1;
               rt_new = rt_inc;
            end
         end
         sprb_pkg::CMD_WRITE: begin
            if (th_inc != tt) begin
               tx_we  = 1'b1;
               wa     = 1'b1;
               th_new = th_inc;
            end
         end
         sprb_pkg::CMD_TX_READY: begin
            if (th != tt) begin
               sv     = 1'b1;
               tt_new = tt_inc;
            end else if (!cfg.console_mode) begin
               sd = 1'b1;
            end
         end
         sprb_pkg::CMD_TX_CLEAR: begin
            th_new = '0;
            tt_new = '0;
         end
         default: begin
         end
      endcase
   end

   assign rc = (rh_new >= rt_new) ? RCW'(rh_new) - RCW'(rt_new)
                                  : RCW'(rh_new) + RCW'(eff_size) - RCW'(rt_new);
   assign tc = (th_new >= tt_new) ? TCW'(th_new) - TCW'(tt_new)
                                  : TCW'(th_new) + TCW'(TX_DEPTH_C) - TCW'(tt_new);

   assign rx_head_in = RA'(rh_new);
   assign rx_tail_in = RA'(rt_new);
   assign tx_head_in = TA'(th_new);
   assign tx_tail_in = TA'(tt_new);

   always_ff @(posedge clock) begin
      if (reset || cfg.rx_size_wr) begin
         rx_head_ff <= '0;
         rx_tail_ff <= '0;
      end else if (out_load) begin
         rx_head_ff <= rx_head_in;
         rx_tail_ff <= rx_tail_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_head_ff <= '0;
         tx_tail_ff <= '0;
      end else if (out_load) begin
         tx_head_ff <= tx_head_in;
         tx_tail_ff <= tx_tail_in;
      end
   end

   // ring memories
   logic [sprb_pkg::BYTE_W-1:0] rx_store_ff [RX_DEPTH];
   logic [sprb_pkg::BYTE_W-1:0] tx_store_ff [TX_DEPTH];
   logic [sprb_pkg::BYTE_W-1:0] rx_rdata_ff, tx_rdata_ff;

   always_ff @(posedge clock) begin
      if (out_load && rx_we) begin
         rx_store_ff[RA'(rh)] <= data_ff;
      end
      if (out_load) begin
         rx_rdata_ff <= rx_store_ff[RA'(rt)];
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && tx_we) begin
         tx_store_ff[TA'(th)] <= data_ff;
      end
      if (out_load) begin
         tx_rdata_ff <= tx_store_ff[TA'(tt)];
      end
   end

   // result register
   logic                                rsp_valid_ff;
   logic                                rv_ff, wa_ff, sv_ff, sd_ff, bk_ff;
   logic [sprb_pkg::RX_COUNT_W-1:0]     rc_ff;
   logic [sprb_pkg::TX_COUNT_W-1:0]     tc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rv_ff <= rv;
         wa_ff <= wa;
         sv_ff <= sv;
         sd_ff <= sd;
         bk_ff <= bk;
         rc_ff <= rc[sprb_pkg::RX_COUNT_W-1:0];
         tc_ff <= tc[sprb_pkg::TX_COUNT_W-1:0];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_valid     = rv_ff;
   assign rsp_read_data      = rv_ff ? rx_rdata_ff : '0;
   assign rsp_write_accepted = wa_ff;
   assign rsp_send_valid     = sv_ff;
   assign rsp_send_byte      = sv_ff ? tx_rdata_ff : '0;
   assign rsp_send_done      = sd_ff;
   assign rsp_break_seen     = bk_ff;
   assign rsp_rx_count       = rc_ff;
   assign rsp_tx_count       = tc_ff;

endmodule

[rtl/sprb_csr.sv]
// Configuration register file behind the APB-style port.
module sprb_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [sprb_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [sprb_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [sprb_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   output sprb_pkg::cfg_type                    cfg
);

   logic [sprb_pkg::RX_SIZE_W-1:0] rx_size_ff;
   logic                           console_ff;
   logic [sprb_pkg::BYTE_W-1:0]    break_key_ff;
   logic                           wr_en;
   logic [sprb_pkg::REG_IDX_W-1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[sprb_pkg::CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_size_ff   <= sprb_pkg::RX_SIZE_RESET;
         console_ff   <= 1'b0;
         break_key_ff <= sprb_pkg::BREAK_KEY_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            sprb_pkg::REG_RX_SIZE: begin
               rx_size_ff <= pwdata[sprb_pkg::RX_SIZE_W-1:0];
            end
            sprb_pkg::REG_CONSOLE: begin
               console_ff <= pwdata[0];
            end
            sprb_pkg::REG_BREAK_KEY: begin
               break_key_ff <= pwdata[sprb_pkg::BYTE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         sprb_pkg::REG_RX_SIZE:   prdata = sprb_pkg::CSR_DATA_W'(rx_size_ff);
         sprb_pkg::REG_CONSOLE:   prdata = sprb_pkg::CSR_DATA_W'(console_ff);
         sprb_pkg::REG_BREAK_KEY: prdata = sprb_pkg::CSR_DATA_W'(break_key_ff);
         default:                 prdata = '0;
      endcase
   end

   assign cfg.rx_size      = rx_size_ff;
   assign cfg.console_mode = console_ff;
   assign cfg.break_key    = break_key_ff;
   assign cfg.rx_size_wr   = wr_en && (reg_idx == sprb_pkg::REG_RX_SIZE);

endmodule

[rtl/sprb_checker.sv]
// Port-level assertions for the serial port ring buffers, bound to the top level.
module sprb_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic                                 rsp_read_valid,
   input logic [sprb_pkg::BYTE_W-1:0]          rsp_read_data,
   input logic                                 rsp_write_accepted,
   input logic                                 rsp_send_valid,
   input logic                                 rsp_send_done,
   input logic                                 rsp_break_seen,
   input logic [sprb_pkg::RX_COUNT_W-1:0]      rsp_rx_count,
   input logic [sprb_pkg::TX_COUNT_W-1:0]      rsp_tx_count
);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_one_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |->
         !rsp_write_accepted && !rsp_send_valid && !rsp_send_done && !rsp_break_seen)
      else $error("read result carries another command's outcome");

   a_break_empties_rx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_break_seen |-> rsp_rx_count == '0)
      else $error("break left bytes in the receive ring");

   a_done_means_tx_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_send_done |-> rsp_tx_count == '0 && !rsp_send_valid)
      else $error("send done with bytes still queued");

   a_stalled_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_read_data) && $stable(rsp_rx_count))
      else $error("stalled result changed");

endmodule

bind serial_port_ring_buffers_core sprb_checker u_sprb_checker (.*);
